// ===== hdl/spr_pkg.sv =====
// Package with the register offsets, transfer codes and result type of the serial port block.
`timescale 1ns / 1ps

package spr_pkg;

   // Transfer kinds carried with each request.
   localparam logic [1:0] MODE_READ    = 2'd0;
   localparam logic [1:0] MODE_WRITE   = 2'd1;
   localparam logic [1:0] MODE_RECEIVE = 2'd2;

   // Implemented register offsets.
   localparam logic [3:0] OFS_LINE_STATUS = 4'h0;
   localparam logic [3:0] OFS_HANDSHAKE   = 4'h2;
   localparam logic [3:0] OFS_BAUD_HIGH   = 4'h4;
   localparam logic [3:0] OFS_BAUD_LOW    = 4'h5;
   localparam logic [3:0] OFS_CONTROL     = 4'h6;
   localparam logic [3:0] OFS_RX_COMMAND  = 4'h7;
   localparam logic [3:0] OFS_TX_COMMAND  = 4'h8;
   localparam logic [3:0] OFS_BUFFER      = 4'h9;

   // Status bit constants.
   localparam logic [7:0] STATUS_FORCED_BITS = 8'h06;
   localparam logic [7:0] STATUS_RX_FULL     = 8'h80;
   localparam logic [7:0] STATUS_CLEARABLE   = 8'hF8;

   // Interrupt request mode held in command bits 6:5.
   localparam logic [1:0] IRQ_MODE_SELECT = 2'd1;

   // Widths of the packed stream words.
   localparam int REQ_TDATA_WIDTH = 16;
   localparam int REQ_TUSER_WIDTH = 2;
   localparam int RSP_TDATA_WIDTH = 24;

   // Result of one request.
   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_irq;
      logic       tx_irq;
      logic       bad_offset;
   } result_type;

endpackage

// ===== hdl/serial_port_register_block.sv =====
// Top level of the serial port register block: stream ports and result register.
//
//  Channel  Direction  Contents
//  req_*    in         tuser: mode; tdata: reg_offset, data_byte
//  rsp_*    out        tdata: read_data, tx_valid, tx_byte, rx_irq, tx_irq, bad_offset
//
// One request is taken per cycle while no result stalls; its result appears in
// the next cycle from the result register, the only storage on the path.
// A request is taken whenever the result register is empty or being drained,
// so a stalled result holds back new requests but never drops one.
// Reset clears all port registers and empties the result register.
`timescale 1ns / 1ps

module serial_port_register_block (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [3:0] reg_offset, [11:4] data_byte, [15:12] zero
   input  logic [spr_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // [1:0] mode
   input  logic [spr_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] rx_irq, [18] tx_irq,
   // [19] bad_offset, [23:20] zero
   output logic [spr_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import spr_pkg::*;

   logic       accept;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   // Take a request when the result register is free or being emptied.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   spr_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_tuser[1:0]),
      .reg_offset (req_tdata[3:0]),
      .data_byte  (req_tdata[11:4]),
      .result     (result)
   );

   // Result register occupancy.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads with each taken request.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.bad_offset,
                        rsp_data_ff.tx_irq,
                        rsp_data_ff.rx_irq,
                        rsp_data_ff.tx_byte,
                        rsp_data_ff.tx_valid,
                        rsp_data_ff.read_data};

endmodule

// ===== hdl/spr_regfile.sv =====
// Register file and request decode of the serial port block.
`timescale 1ns / 1ps

module spr_regfile (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          mode,
   input  logic [3:0]          reg_offset,
   input  logic [7:0]          data_byte,
   output spr_pkg::result_type result
);
   import spr_pkg::*;

   logic [7:0]  line_status_ff,      line_status_in;
   logic [7:0]  handshake_status_ff, handshake_status_in;
   logic [15:0] baud_divisor_ff,     baud_divisor_in;
   logic [7:0]  port_control_ff,     port_control_in;
   logic [7:0]  receive_command_ff,  receive_command_in;
   logic [7:0]  transmit_command_ff, transmit_command_in;
   logic [7:0]  receive_buffer_ff,   receive_buffer_in;
   logic [7:0]  transmit_buffer_ff,  transmit_buffer_in;

   // Decode the request into a result and the next register values.
   always_comb begin
      line_status_in      = line_status_ff;
      handshake_status_in = handshake_status_ff;
      baud_divisor_in     = baud_divisor_ff;
      port_control_in     = port_control_ff;
      receive_command_in  = receive_command_ff;
      transmit_command_in = transmit_command_ff;
      receive_buffer_in   = receive_buffer_ff;
      transmit_buffer_in  = transmit_buffer_ff;
      result              = '0;
      case (mode)
         MODE_READ: begin
            case (reg_offset)
               OFS_LINE_STATUS: result.read_data = line_status_ff | STATUS_FORCED_BITS;
               OFS_HANDSHAKE:   result.read_data = handshake_status_ff;
               OFS_BAUD_HIGH:   result.read_data = {4'b0000, baud_divisor_ff[11:8]};
               OFS_BAUD_LOW:    result.read_data = baud_divisor_ff[7:0];
               OFS_CONTROL:     result.read_data = port_control_ff;
               OFS_RX_COMMAND:  result.read_data = receive_command_ff;
               OFS_TX_COMMAND:  result.read_data = transmit_command_ff;
               OFS_BUFFER:      result.read_data = receive_buffer_ff;
               default:         result.bad_offset = 1'b1;
            endcase
         end
         MODE_WRITE: begin
            case (reg_offset)
               OFS_LINE_STATUS:
                  line_status_in = line_status_ff & ~(data_byte & STATUS_CLEARABLE);
               OFS_HANDSHAKE:  handshake_status_in = data_byte;
               OFS_BAUD_HIGH:  baud_divisor_in = {data_byte, baud_divisor_ff[7:0]};
               OFS_BAUD_LOW:   baud_divisor_in = {baud_divisor_ff[15:8], data_byte};
               OFS_CONTROL:    port_control_in = data_byte;
               OFS_RX_COMMAND: receive_command_in = data_byte;
               OFS_TX_COMMAND: transmit_command_in = data_byte;
               OFS_BUFFER: begin
                  // A write to the transmit buffer sends the byte to the line.
                  transmit_buffer_in = data_byte;
                  result.tx_valid    = 1'b1;
                  result.tx_byte     = data_byte;
                  result.tx_irq      = (transmit_command_ff[6:5] == IRQ_MODE_SELECT);
               end
               default: result.bad_offset = 1'b1;
            endcase
         end
         MODE_RECEIVE: begin
            // A byte from the line fills the receive buffer.
            receive_buffer_in = data_byte;
            line_status_in    = STATUS_RX_FULL;
            result.rx_irq     = (receive_command_ff[6:5] == IRQ_MODE_SELECT);
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Apart from reset, registers change only when a request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_status_ff      <= '0;
         handshake_status_ff <= '0;
         baud_divisor_ff     <= '0;
         port_control_ff     <= '0;
         receive_command_ff  <= '0;
         transmit_command_ff <= '0;
         receive_buffer_ff   <= '0;
         transmit_buffer_ff  <= '0;
      end else if (accept) begin
         line_status_ff      <= line_status_in;
         handshake_status_ff <= handshake_status_in;
         baud_divisor_ff     <= baud_divisor_in;
         port_control_ff     <= port_control_in;
         receive_command_ff  <= receive_command_in;
         transmit_command_ff <= transmit_command_in;
         receive_buffer_ff   <= receive_buffer_in;
         transmit_buffer_ff  <= transmit_buffer_in;
      end
   end

endmodule

// ===== tb/sv/tb_serial_port_register_block.sv =====
// Self-checking testbench for the serial port register block with its own register predictor.
`timescale 1ns / 1ps

// Tracks the port registers and checks each result against the predicted one.
class serial_port_scoreboard;
   logic [7:0]  line_status      = '0;
   logic [7:0]  handshake_status = '0;
   logic [15:0] baud_divisor     = '0;
   logic [7:0]  port_control     = '0;
   logic [7:0]  receive_command  = '0;
   logic [7:0]  transmit_command = '0;
   logic [7:0]  receive_buffer   = '0;
   logic [7:0]  transmit_buffer  = '0;

   spr_pkg::result_type predicted_results[$];

   int unsigned mismatches      = 0;
   int unsigned results_checked = 0;
   int unsigned reads_seen      = 0;
   int unsigned writes_seen     = 0;
   int unsigned receives_seen   = 0;
   int unsigned transmits_seen  = 0;
   int unsigned irqs_seen       = 0;
   int unsigned bad_seen        = 0;

   function automatic bit irq_mode_set(logic [7:0] command);
      return command[6:5] == spr_pkg::IRQ_MODE_SELECT;
   endfunction

   // Apply one accepted request to the register copy and queue its result.
   function void note_request(logic [1:0] mode, logic [3:0] offset, logic [7:0] value);
      spr_pkg::result_type res;
      res = '0;
      case (mode)
         spr_pkg::MODE_READ: begin
            reads_seen++;
            case (offset)
               spr_pkg::OFS_LINE_STATUS: res.read_data = line_status | spr_pkg::STATUS_FORCED_BITS;
               spr_pkg::OFS_HANDSHAKE:   res.read_data = handshake_status;
               spr_pkg::OFS_BAUD_HIGH:   res.read_data = {4'h0, baud_divisor[11:8]};
               spr_pkg::OFS_BAUD_LOW:    res.read_data = baud_divisor[7:0];
               spr_pkg::OFS_CONTROL:     res.read_data = port_control;
               spr_pkg::OFS_RX_COMMAND:  res.read_data = receive_command;
               spr_pkg::OFS_TX_COMMAND:  res.read_data = transmit_command;
               spr_pkg::OFS_BUFFER:      res.read_data = receive_buffer;
               default:                  res.bad_offset = 1'b1;
            endcase
         end
         spr_pkg::MODE_WRITE: begin
            writes_seen++;
            case (offset)
               spr_pkg::OFS_LINE_STATUS:
                  line_status = line_status & ~(value & spr_pkg::STATUS_CLEARABLE);
               spr_pkg::OFS_HANDSHAKE:  handshake_status = value;
               spr_pkg::OFS_BAUD_HIGH:  baud_divisor = {value, baud_divisor[7:0]};
               spr_pkg::OFS_BAUD_LOW:   baud_divisor = {baud_divisor[15:8], value};
               spr_pkg::OFS_CONTROL:    port_control = value;
               spr_pkg::OFS_RX_COMMAND: receive_command = value;
               spr_pkg::OFS_TX_COMMAND: transmit_command = value;
               spr_pkg::OFS_BUFFER: begin
                  transmit_buffer = value;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = transmit_buffer;
                  res.tx_irq   = irq_mode_set(transmit_command);
                  transmits_seen++;
               end
               default: res.bad_offset = 1'b1;
            endcase
         end
         spr_pkg::MODE_RECEIVE: begin
            // The offset plays no part in a byte arriving from the line.
            receives_seen++;
            receive_buffer = value;
            line_status    = spr_pkg::STATUS_RX_FULL;
            res.rx_irq     = irq_mode_set(receive_command);
         end
         default: ;
      endcase
      if (res.rx_irq || res.tx_irq) irqs_seen++;
      if (res.bad_offset) bad_seen++;
      predicted_results.push_back(res);
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare one accepted result word with the oldest prediction.
   function void check_result(logic [spr_pkg::RSP_TDATA_WIDTH-1:0] word);
      spr_pkg::result_type want;
      if (predicted_results.size() == 0) begin
         $error("result 0x%06h arrived with no request outstanding", word);
         mismatches++;
         return;
      end
      want = predicted_results.pop_front();
      results_checked++;
      compare_field("read_data", want.read_data, word[7:0]);
      compare_field("tx_valid", {7'h0, want.tx_valid}, {7'h0, word[8]});
      compare_field("tx_byte", want.tx_byte, word[16:9]);
      compare_field("rx_irq", {7'h0, want.rx_irq}, {7'h0, word[17]});
      compare_field("tx_irq", {7'h0, want.tx_irq}, {7'h0, word[18]});
      compare_field("bad_offset", {7'h0, want.bad_offset}, {7'h0, word[19]});
   endfunction

   function int unsigned outstanding();
      return predicted_results.size();
   endfunction
endclass

module tb_serial_port_register_block;
   import spr_pkg::*;

   localparam logic [1:0] MODE_UNUSED     = 2'd3;
   localparam logic [3:0] OFS_UNUSED_1    = 4'h1;
   localparam logic [3:0] OFS_UNUSED_3    = 4'h3;
   localparam logic [3:0] OFS_UNUSED_A    = 4'hA;
   localparam logic [3:0] OFS_UNUSED_F    = 4'hF;
   localparam int unsigned RANDOM_REQUESTS = 1425;
   localparam int unsigned LONG_HOLD       = 150;
   localparam int unsigned HOLD_AFTER      = 500;
   localparam int unsigned STALL_LIMIT     = 2000;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic [REQ_TUSER_WIDTH-1:0] req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   serial_port_register_block DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   serial_port_scoreboard port_model = new;

   int unsigned idle_cycles    = 0;
   int unsigned send_steady    = 0;
   int unsigned receive_steady = 0;
   bit          long_hold_done = 1'b0;

   // Clock and a single reset pulse at the start.
   always #5 clock = ~clock;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Mostly short gaps, a few long ones, and now and then a run with none.
   function automatic int unsigned next_gap(ref int unsigned steady_run);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_run != 0) begin
         steady_run--;
         return 0;
      end
      if (roll < 3) begin
         steady_run = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic bit offset_mapped(logic [3:0] offset);
      case (offset)
         OFS_LINE_STATUS, OFS_HANDSHAKE, OFS_BAUD_HIGH, OFS_BAUD_LOW,
         OFS_CONTROL, OFS_RX_COMMAND, OFS_TX_COMMAND, OFS_BUFFER: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input logic [1:0] mode, input logic [3:0] offset,
                               input logic [7:0] value);
      int unsigned gap;
      gap = next_gap(send_steady);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'h0, value, offset};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random request: mostly legal register traffic and line bytes.
   task automatic send_random_request();
      int unsigned roll;
      logic [3:0]  offset;
      logic [7:0]  value;
      roll  = $urandom_range(0, 99);
      value = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      do offset = 4'($urandom_range(0, 15)); while (!offset_mapped(offset));
      if (roll < 35) begin
         send_request(MODE_READ, offset, value);
      end else if (roll < 65) begin
         send_request(MODE_WRITE, offset, value);
      end else if (roll < 85) begin
         send_request(MODE_RECEIVE, 4'($urandom_range(0, 15)), value);
      end else if (roll < 97) begin
         do offset = 4'($urandom_range(0, 15)); while (offset_mapped(offset));
         send_request($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, offset, value);
      end else begin
         send_request(MODE_UNUSED, 4'($urandom_range(0, 15)), value);
      end
   endtask

   // Result side: random back-pressure plus one long hold to fill the block.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && port_model.results_checked >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = next_gap(receive_steady);
            if (stall == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Observe both channels on the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            port_model.note_request(req_tuser, req_tdata[3:0], req_tdata[11:4]);
         if (rsp_tvalid && rsp_tready)
            port_model.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles without any transfer.
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Directed requests, then random traffic, then drain and report.
   initial begin
      while (reset) @(posedge clock);

      // Status after reset, then interrupt mode selected on both command registers.
      send_request(MODE_READ, OFS_LINE_STATUS, 8'h00);
      send_request(MODE_WRITE, OFS_TX_COMMAND, 8'h20);
      send_request(MODE_WRITE, OFS_RX_COMMAND, 8'h3F);
      // A received byte fills the buffer and raises its request; offset is ignored.
      send_request(MODE_RECEIVE, OFS_UNUSED_F, 8'hFF);
      send_request(MODE_READ, OFS_LINE_STATUS, 8'hFF);
      send_request(MODE_READ, OFS_BUFFER, 8'h00);
      // Clearing status bits leaves the forced bits reading as set.
      send_request(MODE_WRITE, OFS_LINE_STATUS, 8'hFF);
      send_request(MODE_READ, OFS_LINE_STATUS, 8'h00);
      // Baud divisor halves; the high read returns only a nibble.
      send_request(MODE_WRITE, OFS_BAUD_HIGH, 8'hFF);
      send_request(MODE_WRITE, OFS_BAUD_LOW, 8'h00);
      send_request(MODE_READ, OFS_BAUD_HIGH, 8'h00);
      send_request(MODE_READ, OFS_BAUD_LOW, 8'h00);
      // Transmit with and without the interrupt mode.
      send_request(MODE_WRITE, OFS_BUFFER, 8'hA5);
      send_request(MODE_WRITE, OFS_TX_COMMAND, 8'h60);
      send_request(MODE_WRITE, OFS_BUFFER, 8'h00);
      send_request(MODE_WRITE, OFS_HANDSHAKE, 8'hFF);
      send_request(MODE_READ, OFS_HANDSHAKE, 8'h00);
      send_request(MODE_WRITE, OFS_CONTROL, 8'h80);
      send_request(MODE_READ, OFS_CONTROL, 8'h00);
      send_request(MODE_READ, OFS_RX_COMMAND, 8'h00);
      send_request(MODE_READ, OFS_TX_COMMAND, 8'h00);
      // Unimplemented offsets and the unused mode.
      send_request(MODE_READ, OFS_UNUSED_1, 8'h00);
      send_request(MODE_WRITE, OFS_UNUSED_F, 8'hFF);
      send_request(MODE_READ, OFS_UNUSED_A, 8'h00);
      send_request(MODE_WRITE, OFS_UNUSED_3, 8'h55);
      send_request(MODE_UNUSED, OFS_BUFFER, 8'hFF);

      repeat (RANDOM_REQUESTS) send_random_request();
      req_tvalid <= 1'b0;

      while (port_model.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Covered %0d reads, %0d writes, %0d line bytes, %0d transmits.",
               port_model.reads_seen, port_model.writes_seen,
               port_model.receives_seen, port_model.transmits_seen);
      $display("Saw %0d interrupt requests and %0d unimplemented offsets; %0d results checked.",
               port_model.irqs_seen, port_model.bad_seen, port_model.results_checked);
      if (port_model.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/spr_pkg.sv
hdl/spr_regfile.sv
hdl/serial_port_register_block.sv
tb/sv/tb_serial_port_register_block.sv
